// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked property with asynchronous active-low reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked condition that must never hold.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// ===== rtl/pgf_pkg.sv =====
// Types and width constants of the pairwise gravity force pipeline.
package pgf_pkg;

	localparam int COORD_W = 32;
	localparam int MASS_W  = 32;
	localparam int RAD_W   = 31;
	localparam int GRAV_W  = 32;
	localparam int FORCE_W = 64;

	localparam int MAG_W   = COORD_W + 1;
	localparam int RSUM_W  = RAD_W + 1;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int SUM_W   = SQ_W;
	localparam int RR_W    = 2 * RSUM_W;
	localparam int MP_W    = 2 * MASS_W;
	localparam int GM_W    = GRAV_W + MP_W;
	localparam int PP_W    = GRAV_W + MAG_W;
	localparam int ROOT_W  = MAG_W;
	localparam int D2_W    = 2 * ROOT_W;
	localparam int D3_W    = 3 * ROOT_W;
	localparam int NUM_W   = GM_W + MAG_W;
	localparam int QUO_W   = FORCE_W;

	localparam int FRONT_LAT = 4;
	localparam int SCALE_LAT = 3;
	localparam int DIV_LAT   = QUO_W + 1;
	localparam int PIPE_LAT  = FRONT_LAT + ROOT_W + SCALE_LAT + DIV_LAT + 1;

	typedef struct packed {
		logic signed [COORD_W-1:0] a_x;
		logic signed [COORD_W-1:0] a_y;
		logic signed [COORD_W-1:0] a_z;
		logic signed [COORD_W-1:0] b_x;
		logic signed [COORD_W-1:0] b_y;
		logic signed [COORD_W-1:0] b_z;
		logic [MASS_W-1:0]         mass_a;
		logic [MASS_W-1:0]         mass_b;
		logic [RAD_W-1:0]          radius_a;
		logic [RAD_W-1:0]          radius_b;
	} pair_t;

	typedef struct packed {
		logic signed [FORCE_W-1:0] force_x;
		logic signed [FORCE_W-1:0] force_y;
		logic signed [FORCE_W-1:0] force_z;
		logic                      collided;
		logic                      saturated;
	} force_t;

	// Per-item data that rides alongside the square root
	typedef struct packed {
		logic [GM_W-1:0]           gm;
		logic [2:0][MAG_W-1:0]     mag;
		logic [2:0]                neg;
		logic                      coll;
	} side_t;

	// Per-item flags that ride alongside the dividers
	typedef struct packed {
		logic [2:0] neg;
		logic [2:0] zero;
		logic       coll;
	} tail_t;

endpackage

// ===== rtl/pairwise_gravity_force.sv =====
// Top level of the pairwise gravity force pipeline.
//
// channel   direction  handshake              payload
// item in   input      start, busy            pair   (pgf_pkg::pair_t)
// result    output     done (one-cycle pulse) result (pgf_pkg::force_t)
// config    input      cfg_valid, cfg_ready   cfg_data (G, unsigned Q32.0)
//
// One item enters per cycle; busy stays low, so every start is taken.
// Each result passes through 4 front stages, 33 square
// root stages, 3 cube stages, 65 divider stages and the output register.
// The divider, one quotient bit per stage, holds most of those stages.
// Reset clears the valid bits and sets G to 1; payload registers are not reset.
// The receiver takes each result in the cycle it appears.
module pairwise_gravity_force (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  pgf_pkg::pair_t               pair,
	output logic                         done,
	output pgf_pkg::force_t              result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pgf_pkg::GRAV_W-1:0]   cfg_data
);
	localparam int GW = pgf_pkg::GRAV_W;
	localparam int SW = pgf_pkg::SUM_W;
	localparam int RW = pgf_pkg::ROOT_W;
	localparam int DW = pgf_pkg::D3_W;
	localparam int NW = pgf_pkg::NUM_W;
	localparam int QW = pgf_pkg::QUO_W;
	localparam int FW = pgf_pkg::FORCE_W;
	localparam int TL = pgf_pkg::DIV_LAT;

	logic [GW-1:0]        grav_q;
	logic                 front_vld, root_vld, scale_vld;
	logic [SW-1:0]        sum;
	pgf_pkg::side_t       side_f, side_r;
	logic [RW-1:0]        root;
	logic [DW-1:0]        den;
	logic [2:0][NW-1:0]   num;
	pgf_pkg::tail_t       tail;
	pgf_pkg::tail_t       tail_s [TL];
	logic [2:0]           div_vld, big;
	logic [2:0][QW-1:0]   quo;

	logic [2:0][QW-1:0]   bound_c, qv_c;
	logic [2:0][FW-1:0]   force_c;
	logic [2:0]           over_c;
	logic                 sat_c;
	pgf_pkg::force_t      result_q;
	logic                 done_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Hold G; writes must arrive only while the pipeline is empty (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= GW'(1);
		end else if (cfg_valid && cfg_ready) begin
			grav_q <= cfg_data;
		end
	end

	pgf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.pair      (pair),
		.grav      (grav_q),
		.out_valid (front_vld),
		.sum       (sum),
		.side      (side_f)
	);

	pgf_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_vld),
		.sum       (sum),
		.side_in   (side_f),
		.out_valid (root_vld),
		.root      (root),
		.side_out  (side_r)
	);

	pgf_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_vld),
		.root      (root),
		.side      (side_r),
		.out_valid (scale_vld),
		.den       (den),
		.num       (num),
		.tail      (tail)
	);

	for (genvar k = 0; k < 3; k++) begin : g_axis
		pgf_div u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (scale_vld),
			.num       (num[k]),
			.den       (den),
			.out_valid (div_vld[k]),
			.quo       (quo[k]),
			.big       (big[k])
		);
	end

	// Delay the sign, zero and collision flags alongside the dividers
	always_ff @(posedge clk) begin
		tail_s[0] <= tail;
		for (int i = 1; i < TL; i++) begin
			tail_s[i] <= tail_s[i-1];
		end
	end

	// Clip to range, apply the opposite sign, drop zero axes and collisions
	always_comb begin
		sat_c = 1'b0;
		for (int k = 0; k < 3; k++) begin
			bound_c[k] = tail_s[TL-1].neg[k] ? {1'b0, {(QW-1){1'b1}}}
				: {1'b1, (QW-1)'(0)};
			over_c[k]  = big[k] || (quo[k] > bound_c[k]);
			qv_c[k]    = over_c[k] ? bound_c[k] : quo[k];
			force_c[k] = '0;
			if (!tail_s[TL-1].zero[k]) begin
				force_c[k] = tail_s[TL-1].neg[k] ? qv_c[k] : (~qv_c[k] + QW'(1));
				sat_c      = sat_c | over_c[k];
			end
			if (tail_s[TL-1].coll) begin
				force_c[k] = '0;
			end
		end
		if (tail_s[TL-1].coll) begin
			sat_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld[0];
		end
	end

	always_ff @(posedge clk) begin
		result_q.force_x   <= force_c[0];
		result_q.force_y   <= force_c[1];
		result_q.force_z   <= force_c[2];
		result_q.collided  <= tail_s[TL-1].coll;
		result_q.saturated <= sat_c;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/pgf_front.sv =====
// Front stages: axis offsets, squares, mass products and collision test.
module pgf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  pgf_pkg::pair_t               pair,
	input  logic [pgf_pkg::GRAV_W-1:0]   grav,
	output logic                         out_valid,
	output logic [pgf_pkg::SUM_W-1:0]    sum,
	output pgf_pkg::side_t               side
);
	localparam int CW = pgf_pkg::COORD_W;
	localparam int MW = pgf_pkg::MAG_W;
	localparam int SW = pgf_pkg::SUM_W;
	localparam int QW = pgf_pkg::SQ_W;
	localparam int RW = pgf_pkg::RR_W;
	localparam int PW = pgf_pkg::MP_W;
	localparam int GW = pgf_pkg::GM_W;
	localparam int XW = pgf_pkg::RSUM_W;
	localparam int HW = pgf_pkg::GRAV_W + pgf_pkg::MASS_W;

	logic [2:0][CW-1:0] pa, pb;
	logic [2:0][MW-1:0] diff_c, mag_c;
	logic [2:0]         neg_c;

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic [2:0][MW-1:0] mag_s1, mag_s2, mag_s3, mag_s4;
	logic [2:0]         neg_s1, neg_s2, neg_s3, neg_s4;
	logic [XW-1:0]      rsum_s1;
	logic [PW-1:0]      mp_s1;
	logic [2:0][QW-1:0] sq_s2;
	logic [RW-1:0]      rr_s2, rr_s3;
	logic [HW-1:0]      gml_s2, gmh_s2;
	logic [SW-1:0]      sum_s3, sum_s4;
	logic [GW-1:0]      gm_s3, gm_s4;
	logic               coll_s4;

	assign pa = {pair.a_z, pair.a_y, pair.a_x};
	assign pb = {pair.b_z, pair.b_y, pair.b_x};

	// Take signed offsets apart into sign and magnitude
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff_c[k] = {pa[k][CW-1], pa[k]} - {pb[k][CW-1], pb[k]};
			neg_c[k]  = diff_c[k][MW-1];
			mag_c[k]  = neg_c[k] ? (~diff_c[k] + MW'(1)) : diff_c[k];
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		mag_s1  <= mag_c;
		neg_s1  <= neg_c;
		rsum_s1 <= XW'(pair.radius_a) + XW'(pair.radius_b);
		mp_s1   <= PW'(pair.mass_a) * PW'(pair.mass_b);

		for (int k = 0; k < 3; k++) begin
			sq_s2[k] <= QW'(mag_s1[k]) * QW'(mag_s1[k]);
		end
		rr_s2  <= RW'(rsum_s1) * RW'(rsum_s1);
		gml_s2 <= HW'(grav) * HW'(mp_s1[PW/2-1:0]);
		gmh_s2 <= HW'(grav) * HW'(mp_s1[PW-1:PW/2]);
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;

		sum_s3 <= SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);
		gm_s3  <= GW'(gml_s2) + {gmh_s2, (PW/2)'(0)};
		rr_s3  <= rr_s2;
		mag_s3 <= mag_s2;
		neg_s3 <= neg_s2;

		coll_s4 <= (sum_s3 <= SW'(rr_s3));
		sum_s4  <= sum_s3;
		gm_s4   <= gm_s3;
		mag_s4  <= mag_s3;
		neg_s4  <= neg_s3;
	end

	assign out_valid = vld_s4;
	assign sum       = sum_s4;

	always_comb begin
		side.gm   = gm_s4;
		side.mag  = mag_s4;
		side.neg  = neg_s4;
		side.coll = coll_s4;
	end

endmodule

// ===== rtl/pgf_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module pgf_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [pgf_pkg::SUM_W-1:0]    sum,
	input  pgf_pkg::side_t               side_in,
	output logic                         out_valid,
	output logic [pgf_pkg::ROOT_W-1:0]   root,
	output pgf_pkg::side_t               side_out
);
	localparam int SW = pgf_pkg::SUM_W;
	localparam int RW = pgf_pkg::ROOT_W;

	logic                 vld_s  [RW];
	logic [SW-1:0]        rem_s  [RW];
	logic [RW-1:0]        root_s [RW];
	pgf_pkg::side_t       side_s [RW];

	for (genvar i = 0; i < RW; i++) begin : g_step
		localparam int B = RW - 1 - i;
		logic                 vld_i;
		logic [SW-1:0]        rem_i, trial;
		logic [RW-1:0]        root_i;
		pgf_pkg::side_t       side_i;
		logic                 ge;

		if (i == 0) begin : g_first
			assign vld_i  = in_valid;
			assign rem_i  = sum;
			assign root_i = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign vld_i  = vld_s[i-1];
			assign rem_i  = rem_s[i-1];
			assign root_i = root_s[i-1];
			assign side_i = side_s[i-1];
		end

		// Trial subtrahend (2r + 2^B) * 2^B
		assign trial = (SW'(root_i) << (B + 1)) | (SW'(1) << (2 * B));
		assign ge    = (rem_i >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i]  <= ge ? (rem_i - trial) : rem_i;
			root_s[i] <= root_i | (RW'(ge) << B);
			side_s[i] <= side_i;
		end
	end

	assign out_valid = vld_s[RW-1];
	assign root      = root_s[RW-1];
	assign side_out  = side_s[RW-1];

endmodule

// ===== rtl/pgf_scale.sv =====
// Distance cube and per-axis numerators G*m_a*m_b*|D|.
module pgf_scale (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [pgf_pkg::ROOT_W-1:0]        root,
	input  pgf_pkg::side_t                    side,
	output logic                              out_valid,
	output logic [pgf_pkg::D3_W-1:0]          den,
	output logic [2:0][pgf_pkg::NUM_W-1:0]    num,
	output pgf_pkg::tail_t                    tail
);
	localparam int RW  = pgf_pkg::ROOT_W;
	localparam int D2W = pgf_pkg::D2_W;
	localparam int D3W = pgf_pkg::D3_W;
	localparam int NW  = pgf_pkg::NUM_W;
	localparam int PPW = pgf_pkg::PP_W;
	localparam int LW  = pgf_pkg::GRAV_W;

	logic                        vld_s1, vld_s2, vld_s3;
	logic [D2W-1:0]              d2_s1;
	logic [RW-1:0]               root_s1;
	logic [2:0][2:0][PPW-1:0]    prod_s1;
	logic [D2W-1:0]              plo_s2, phi_s2;
	logic [2:0][NW-1:0]          num_s2, num_s3;
	logic [D3W-1:0]              den_s3;
	pgf_pkg::tail_t              tail_c, tail_s1, tail_s2, tail_s3;

	always_comb begin
		tail_c.neg  = side.neg;
		tail_c.coll = side.coll;
		for (int k = 0; k < 3; k++) begin
			tail_c.zero[k] = (side.mag[k] == '0);
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Partial products, then sums; the cube is split in two halves of d^2
	always_ff @(posedge clk) begin
		d2_s1   <= D2W'(root) * D2W'(root);
		root_s1 <= root;
		tail_s1 <= tail_c;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s1[k][j] <= PPW'(side.gm[j*LW +: LW]) * PPW'(side.mag[k]);
			end
		end

		plo_s2  <= D2W'(d2_s1[RW-1:0]) * D2W'(root_s1);
		phi_s2  <= D2W'(d2_s1[D2W-1:RW]) * D2W'(root_s1);
		tail_s2 <= tail_s1;
		for (int k = 0; k < 3; k++) begin
			num_s2[k] <= NW'(prod_s1[k][0]) + (NW'(prod_s1[k][1]) << LW)
				+ (NW'(prod_s1[k][2]) << (2 * LW));
		end

		den_s3  <= D3W'(plo_s2) + (D3W'(phi_s2) << RW);
		num_s3  <= num_s2;
		tail_s3 <= tail_s2;
	end

	assign out_valid = vld_s3;
	assign den       = den_s3;
	assign num       = num_s3;
	assign tail      = tail_s3;

endmodule

// ===== rtl/pgf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module pgf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [pgf_pkg::NUM_W-1:0]   num,
	input  logic [pgf_pkg::D3_W-1:0]    den,
	output logic                        out_valid,
	output logic [pgf_pkg::QUO_W-1:0]   quo,
	output logic                        big
);
	localparam int NW = pgf_pkg::NUM_W;
	localparam int DW = pgf_pkg::D3_W;
	localparam int QW = pgf_pkg::QUO_W;
	localparam int HW = NW - QW;

	logic            vld_s  [QW+1];
	logic [DW-1:0]   rem_s  [QW+1];
	logic [QW-1:0]   low_s  [QW+1];
	logic [DW-1:0]   den_s  [QW+1];
	logic [QW-1:0]   quo_s  [QW+1];
	logic            big_s  [QW+1];

	// Entry stage: quotient beyond QW bits when the upper numerator reaches den
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		big_s[0] <= (DW'(num[NW-1:QW]) >= den);
		rem_s[0] <= DW'(num[NW-1:QW]);
		low_s[0] <= num[QW-1:0];
		den_s[0] <= den;
		quo_s[0] <= '0;
	end

	for (genvar j = 0; j < QW; j++) begin : g_bit
		logic [DW:0] shifted, dif;
		logic        ge;

		assign shifted = {rem_s[j], low_s[j][QW-1]};
		assign dif     = shifted - {1'b0, den_s[j]};
		assign ge      = (shifted >= {1'b0, den_s[j]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? dif[DW-1:0] : shifted[DW-1:0];
			low_s[j+1] <= {low_s[j][QW-2:0], 1'b0};
			den_s[j+1] <= den_s[j];
			quo_s[j+1] <= {quo_s[j][QW-2:0], ge};
			big_s[j+1] <= big_s[j];
		end
	end

	assign out_valid = vld_s[QW];
	assign quo       = quo_s[QW];
	assign big       = big_s[QW];

endmodule

// ===== rtl/pgf_checker.sv =====
// Port-level checker for the pairwise gravity force block, with its bind.
`include "assert_macros.svh"

module pgf_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  pgf_pkg::pair_t     pair,
	input  logic               done,
	input  pgf_pkg::force_t    result
);
	localparam int LAT = pgf_pkg::PIPE_LAT;

	// Every accepted item produces its result after the fixed latency
	`ASSERT_PROP(a_lat_fwd, clk, arst_n, (start && !busy) |-> ##LAT done, "result missing")
	// No result without an item accepted the fixed latency earlier
	`ASSERT_PROP(a_lat_back, clk, arst_n, done |-> $past(start && !busy, LAT), "extra result")
	// A collision gives zero force and no clipping
	`ASSERT_PROP(a_coll, clk, arst_n, (done && result.collided) |-> (result.force_x == '0 && result.force_y == '0 && result.force_z == '0 && !result.saturated), "collision not zeroed")
	// No offset on the x axis gives zero force on that axis
	`ASSERT_PROP(a_zero_x, clk, arst_n, (done && $past(pair.a_x == pair.b_x, LAT)) |-> (result.force_x == '0), "x force nonzero")
	// Clipping never comes with a collision
	`ASSERT_NEVER(a_sat_coll, clk, arst_n, done && result.saturated && result.collided, "clip on collision")

endmodule

bind pairwise_gravity_force pgf_checker u_pgf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.pair   (pair),
	.done   (done),
	.result (result)
);

// ===== tb/pairwise_gravity_force_tb.sv =====
// Self-checking testbench for the pairwise gravity force pipeline.
`timescale 1ns / 1ps

module pairwise_gravity_force_tb;

	localparam int DRAIN_CYCLES = pgf_pkg::PIPE_LAT + 20;

	// Track expected forces and compare them with the results that come out
	class force_scoreboard;
		logic [pgf_pkg::GRAV_W-1:0] grav;
		pgf_pkg::force_t            expected_forces[$];
		int                         errors;

		function new();
			grav   = 1;
			errors = 0;
		endfunction

		function void set_grav(logic [pgf_pkg::GRAV_W-1:0] g);
			grav = g;
		endfunction

		function int pending();
			return expected_forces.size();
		endfunction

		// Compute the force on the first body, exact on wide integers
		function void note_pair(pgf_pkg::pair_t p);
			logic signed [63:0] pa[3];
			logic signed [63:0] pb[3];
			logic [63:0]  diff;
			logic [63:0]  mag[3];
			bit           neg[3];
			logic [255:0] sum, rr, d, t, d3, gm, num, quo;
			logic [63:0]  bound, qv;
			logic [63:0]  comp[3];
			bit           sat;
			pgf_pkg::force_t f;
			pa[0] = p.a_x; pa[1] = p.a_y; pa[2] = p.a_z;
			pb[0] = p.b_x; pb[1] = p.b_y; pb[2] = p.b_z;
			sum = '0;
			sat = 0;
			for (int k = 0; k < 3; k++) begin
				diff   = pa[k] - pb[k];
				neg[k] = diff[63];
				mag[k] = neg[k] ? -diff : diff;
				sum    = sum + 256'(mag[k]) * 256'(mag[k]);
			end
			rr = 256'(33'(p.radius_a) + 33'(p.radius_b));
			rr = rr * rr;
			f = '0;
			if (sum <= rr) begin
				f.collided = 1'b1;
			end else begin
				// floor of the square root, one bit at a time
				d = '0;
				for (int b = 55; b >= 0; b--) begin
					t = d | (256'(1) << b);
					if (t * t <= sum)
						d = t;
				end
				d3 = d * d * d;
				gm = 256'(grav) * 256'(p.mass_a) * 256'(p.mass_b);
				for (int k = 0; k < 3; k++) begin
					comp[k] = '0;
					if (mag[k] != 0) begin
						num   = gm * 256'(mag[k]);
						quo   = num / d3;
						qv    = quo[63:0];
						bound = neg[k] ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
						if (quo[255:64] != 0 || qv > bound) begin
							qv  = bound;
							sat = 1;
						end
						// force points against the offset
						comp[k] = neg[k] ? qv : -qv;
					end
				end
				f.force_x   = comp[0];
				f.force_y   = comp[1];
				f.force_z   = comp[2];
				f.saturated = sat;
			end
			expected_forces.push_back(f);
		endfunction

		function void check_force(pgf_pkg::force_t got);
			pgf_pkg::force_t e;
			if (expected_forces.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
				return;
			end
			e = expected_forces.pop_front();
			if (got.force_x !== e.force_x) begin
				$error("force_x expected %0d got %0d", e.force_x, got.force_x);
				errors++;
			end
			if (got.force_y !== e.force_y) begin
				$error("force_y expected %0d got %0d", e.force_y, got.force_y);
				errors++;
			end
			if (got.force_z !== e.force_z) begin
				$error("force_z expected %0d got %0d", e.force_z, got.force_z);
				errors++;
			end
			if (got.collided !== e.collided) begin
				$error("collided expected %0b got %0b", e.collided, got.collided);
				errors++;
			end
			if (got.saturated !== e.saturated) begin
				$error("saturated expected %0b got %0b", e.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	pgf_pkg::pair_t               pair;
	logic                         done;
	pgf_pkg::force_t              result;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [pgf_pkg::GRAV_W-1:0]   cfg_data;

	force_scoreboard     sb;
	bit                  allow_idle;

	pairwise_gravity_force dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.pair     (pair),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Check each result in the cycle it is strobed
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_force(result);
	end

	// Hold the start line high until the item is taken
	task automatic send_pair(pgf_pkg::pair_t p);
		@(negedge clk);
		start <= 1'b1;
		pair  <= p;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		sb.note_pair(p);
	endtask

	// Now and then, while idles are allowed, drop start for a random burst
	task automatic maybe_idle();
		int n;
		if (!allow_idle || $urandom_range(0, 3) != 0)
			return;
		n = $urandom_range(1, 12);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Wait until every result is in and the pipeline has emptied
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write G through the configuration channel while idle
	task automatic write_grav(logic [pgf_pkg::GRAV_W-1:0] g);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= g;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		sb.set_grav(g);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic pgf_pkg::pair_t make_pair(int ax, int ay, int az, int bx, int by,
			int bz, logic [31:0] ma, logic [31:0] mb, logic [30:0] ra, logic [30:0] rb);
		pgf_pkg::pair_t p;
		p.a_x = ax; p.a_y = ay; p.a_z = az;
		p.b_x = bx; p.b_y = by; p.b_z = bz;
		p.mass_a = ma; p.mass_b = mb;
		p.radius_a = ra; p.radius_b = rb;
		return p;
	endfunction

	// Random pair: mostly close, well separated bodies, sometimes pure noise
	function automatic pgf_pkg::pair_t random_pair();
		pgf_pkg::pair_t p;
		int    sel;
		logic signed [31:0] dlt;
		p.a_x      = $urandom;
		p.a_y      = $urandom;
		p.a_z      = $urandom;
		p.b_x      = $urandom;
		p.b_y      = $urandom;
		p.b_z      = $urandom;
		p.mass_a   = $urandom;
		p.mass_b   = $urandom;
		p.radius_a = 31'($urandom);
		p.radius_b = 31'($urandom);
		sel = $urandom_range(0, 9);
		if (sel < 8) begin
			dlt = $signed($urandom) >>> $urandom_range(0, 28); p.b_x = p.a_x - dlt;
			dlt = $signed($urandom) >>> $urandom_range(0, 28); p.b_y = p.a_y - dlt;
			dlt = $signed($urandom) >>> $urandom_range(0, 28); p.b_z = p.a_z - dlt;
			if ($urandom_range(0, 5) == 0)
				p.b_y = p.a_y;
			p.mass_a   = $urandom >> $urandom_range(0, 31);
			p.mass_b   = $urandom >> $urandom_range(0, 31);
			p.radius_a = 31'($urandom >> $urandom_range(8, 31));
			p.radius_b = 31'($urandom >> $urandom_range(8, 31));
			if (sel == 7) begin
				p.radius_a = 31'($urandom >> $urandom_range(1, 12));
				p.radius_b = 31'($urandom >> $urandom_range(1, 12));
			end
		end
		return p;
	endfunction

	initial begin
		logic [pgf_pkg::GRAV_W-1:0] g_set[5];
		arst_n    = 1'b0;
		start     = 1'b0;
		pair      = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		allow_idle = 1'b1;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, collisions, zero offsets and saturation
		write_grav(32'hFFFF_FFFF);
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF,
			0, '1, '1, 0, 0));
		send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, '1, '1, 0, 0));
		send_pair(make_pair(1, 0, 0, 0, 0, 0, '1, '1, 0, 0));
		send_pair(make_pair(0, -1, 0, 0, 0, 0, '1, '1, 0, 0));
		send_pair(make_pair(0, 0, 1, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0));
		// touching exactly: d equals the radius sum
		send_pair(make_pair(32'h0003_0000, 0, 0, 0, 0, 0, '1, '1, 32'h0001_0000,
			32'h0002_0000));
		send_pair(make_pair(32'h0003_0001, 0, 0, 0, 0, 0, '1, '1, 32'h0001_0000,
			32'h0002_0000));
		send_pair(make_pair(5, 5, 5, 5, 5, 5, '1, '1, '1, '1));
		send_pair(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, '1, '1, '1, '1));
		send_pair(make_pair(32'h0010_0000, -32'h0020_0000, 32'h0003_0000, 0, 0, 0,
			32'h0100_0000, 32'h0010_0000, 1, 1));
		send_pair(make_pair(-32'h0010_0000, 32'h0020_0000, 0, 0, 0, 32'h0003_0000,
			0, '1, 1, 1));
		write_grav(32'h0);
		send_pair(make_pair(1, 0, 0, 0, 0, 0, '1, '1, 0, 0));
		send_pair(make_pair(32'h0001_0000, 2, 3, 0, 0, 0, '1, '1, 0, 0));
		write_grav(32'h0000_0001);
		send_pair(make_pair(1, 1, 1, 0, 0, 0, '1, '1, 0, 0));
		send_pair(make_pair(32'h4000_0000, 0, 0, 0, 0, 0, '1, '1, 0, 0));

		// Random phases at several settings of G
		g_set[0] = $urandom;
		g_set[1] = 32'hFFFF_FFFF;
		g_set[2] = $urandom >> $urandom_range(8, 28);
		g_set[3] = 32'h0;
		g_set[4] = 32'h0000_0001;
		for (int ph = 0; ph < 5; ph++) begin
			write_grav(g_set[ph]);
			for (int i = 0; i < 190; i++) begin
				if (ph == 4 && i >= 120)
					allow_idle = 1'b0;
				// sender pause until the pipeline has emptied
				if (ph == 1 && i == 95)
					drain();
				send_pair(random_pair());
				maybe_idle();
			end
		end

		drain();
		if (sb.errors == 0)
			$display("pairwise_gravity_force regression: pass");
		else
			$display("pairwise_gravity_force regression: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("pairwise_gravity_force regression: fail");
		$finish;
	end

endmodule
